// ===== design/lcb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcb_pkg
// types and codes shared by the lru cache with byte budget
// ----------------------------------------------------------------------------
package lcb_pkg;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic CFG_COUNT_LIMIT = 1'b0;
    localparam logic CFG_BYTE_LIMIT  = 1'b1;

    localparam logic [9:0]  COUNT_LIMIT_RESET = 10'd512;
    localparam logic [26:0] BYTE_LIMIT_RESET  = 27'd16777216;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] key_id;
        logic        stamp_valid;
        logic [63:0] stamp_size;
        logic [63:0] stamp_modified;
        logic [63:0] stamp_created;
        logic [26:0] entry_bytes;
    } t_in_word;

    typedef struct packed {
        logic        hit;
        logic [8:0]  slot;
        logic        stored;
        logic [9:0]  evicted_count;
        logic [9:0]  entry_count;
        logic [26:0] bytes_used;
        logic [31:0] hit_total;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,     // scan for key
        ST_DECIDE,
        ST_RANK,     // rank adjust sweep
        ST_EVSCAN,   // search for least recent entry
        ST_EVCHK,
        ST_STORE,
        ST_FLUSH,
        ST_OUT
    } t_state;

    // rank adjust modes for one sweep
    typedef enum logic [1:0] {
        RK_DROP,     // rank > r : decrement
        RK_HIT,      // rank < r : increment
        RK_ALL       // every valid: increment
    } t_rank_mode;

endpackage

// ===== design/lru_cache_with_byte_budget.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cache_with_byte_budget
// recency ordered table of keyed entries with count limit and byte budget
// ----------------------------------------------------------------------------
// a lookup scans for the key and, on a hit or stale key, sweeps the ranks; an insert
// scans, sweeps out a replaced key, evicts least recent entries until within limits,
// then raises every rank and stores if a slot is free; a flush clears all entries
// one item at a time, each sweep walks the two-port entry memory a slot a cycle;
// the next word is taken once the result is registered, even while it waits
// reset: valid bits, counters and limits are cleared/restored at once, no sweep
module lru_cache_with_byte_budget #(
    parameter int ENTRIES = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lcb_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lcb_pkg::t_out_word o_out_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [26:0]        i_cfg_data
);
    import lcb_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    // memories
    logic [63:0] m_key [ENTRIES];
    logic [191:0] m_stamp [ENTRIES];
    logic [26:0] m_cost [ENTRIES];
    logic [AW-1:0] m_rank [ENTRIES];
    logic [ENTRIES-1:0] r_valid, n_valid;

    t_state r_state, n_state;
    t_rank_mode r_mode, n_mode;
    t_in_word r_item, n_item;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_tgt, n_tgt;       // target slot
    logic r_tgt_ok, n_tgt_ok;
    logic [26:0] r_tcost, n_tcost;     // cost of target slot
    logic [AW-1:0] r_free, n_free;
    logic [AW-1:0] r_rk, n_rk;         // rank of reference
    logic [CW-1:0] r_live, n_live;
    logic [26:0] r_bytes, n_bytes;
    logic [31:0] r_hits, n_hits;
    logic [9:0] r_cnt_lim;
    logic [26:0] r_byte_lim;
    t_out_word r_out, n_out;
    t_out_word r_res, n_res;
    logic r_out_valid, n_out_valid;
    logic [9:0] r_ev, n_ev;

    // registered memory read
    logic [63:0] r_rd_key;
    logic [191:0] r_rd_stamp;
    logic [26:0] r_rd_cost;
    logic [AW-1:0] r_rd_rank;
    logic [AW-1:0] rd_addr;
    logic wr_en;
    logic [AW-1:0] wr_addr;
    logic rk_we;
    logic [AW-1:0] rk_wdata;

    always_ff @(posedge i_clk) begin
        r_rd_key   <= m_key[rd_addr];
        r_rd_stamp <= m_stamp[rd_addr];
        r_rd_cost  <= m_cost[rd_addr];
        r_rd_rank  <= m_rank[rd_addr];
        if (wr_en) begin
            m_key[wr_addr]   <= r_item.key_id;
            m_stamp[wr_addr] <= {r_item.stamp_size, r_item.stamp_modified,
                                 r_item.stamp_created};
            m_cost[wr_addr]  <= r_item.entry_bytes;
        end
        if (rk_we) begin
            m_rank[wr_addr] <= rk_wdata;
        end
    end

    // pipeline: read issued at r_idx, data valid in the next cycle at r_pidx
    logic [AW-1:0] r_pidx;
    logic r_pv;
    logic        pv_valid;
    logic [CW-1:0] eff_lim;
    logic [27:0] bsum;
    logic over;

    assign pv_valid = r_pv && r_valid[r_pidx];
    assign eff_lim  = (r_cnt_lim > 10'(ENTRIES)) ? CW'(ENTRIES) : CW'(r_cnt_lim);
    assign bsum     = {1'b0, r_bytes} + {1'b0, r_item.entry_bytes};
    assign over     = (r_live >= eff_lim) || (bsum > {1'b0, r_byte_lim});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_live <= '0;
            r_bytes <= '0;
            r_hits <= '0;
            r_out_valid <= 1'b0;
            r_cnt_lim <= COUNT_LIMIT_RESET;
            r_byte_lim <= BYTE_LIMIT_RESET;
            r_pv <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_live <= n_live;
            r_bytes <= n_bytes;
            r_hits <= n_hits;
            r_out_valid <= n_out_valid;
            r_pv <= (n_state == r_state) && (r_state == ST_FIND || r_state == ST_RANK
                     || r_state == ST_EVSCAN);
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_COUNT_LIMIT: r_cnt_lim <= i_cfg_data[9:0];
                    CFG_BYTE_LIMIT:  r_byte_lim <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_item <= n_item;
        r_idx <= n_idx;
        r_pidx <= r_idx;
        r_tgt <= n_tgt;
        r_tgt_ok <= n_tgt_ok;
        r_tcost <= n_tcost;
        r_free <= n_free;
        r_rk <= n_rk;
        r_out <= n_out;
        r_res <= n_res;
        r_ev <= n_ev;
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_res;

    always_comb begin
        n_state = r_state;
        n_mode = r_mode;
        n_item = r_item;
        n_idx = r_idx;
        n_tgt = r_tgt;
        n_tgt_ok = r_tgt_ok;
        n_tcost = r_tcost;
        n_free = r_free;
        n_rk = r_rk;
        n_valid = r_valid;
        n_live = r_live;
        n_bytes = r_bytes;
        n_hits = r_hits;
        n_out = r_out;
        n_res = r_res;
        n_out_valid = r_out_valid;
        n_ev = r_ev;
        rd_addr = r_idx;
        wr_en = 1'b0;
        wr_addr = r_tgt;
        rk_we = 1'b0;
        rk_wdata = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && !o_in_stall) begin
                    n_item = i_in_word;
                    n_idx = '0;
                    n_tgt_ok = 1'b0;
                    n_ev = '0;
                    n_out = '0;
                    case (i_in_word.operation)
                        OP_LOOKUP: n_state = ST_FIND;
                        OP_INSERT: begin
                            if (i_in_word.stamp_valid &&
                                i_in_word.entry_bytes <= r_byte_lim) begin
                                n_state = ST_FIND;
                            end else begin
                                n_state = ST_OUT;
                            end
                        end
                        OP_FLUSH: n_state = ST_FLUSH;
                        default: n_state = ST_OUT;
                    endcase
                end
            end
            ST_FIND: begin
                if (r_idx != LAST) begin
                    n_idx = r_idx + AW'(1);
                end
                if (r_pv) begin
                    if (pv_valid && r_rd_key == r_item.key_id && !r_tgt_ok) begin
                        n_tgt = r_pidx;
                        n_tgt_ok = 1'b1;
                        n_rk = r_rd_rank;
                        n_tcost = r_rd_cost;
                    end
                    if (r_pidx == LAST) begin
                        n_state = ST_DECIDE;
                    end
                end else if (ENTRIES == 1 && r_idx == LAST) begin
                    n_state = ST_FIND;
                end
            end
            ST_DECIDE: begin
                // stamp of target read at r_tgt, available next cycle
                rd_addr = r_tgt;
                n_state = ST_RANK;
                n_idx = '0;
                if (!r_tgt_ok) begin
                    n_state = (r_item.operation == OP_LOOKUP) ? ST_OUT : ST_EVCHK;
                end else if (r_item.operation == OP_INSERT) begin
                    n_mode = RK_DROP;
                    n_valid[r_tgt] = 1'b0;
                    n_live = r_live - CW'(1);
                    n_bytes = r_bytes - r_tcost;
                    n_ev = r_ev + 10'd1;
                end else begin
                    // stamp compare needs the registered read, done at first rank cycle
                    n_mode = RK_HIT;
                end
            end
            ST_RANK: begin
                if (!r_pv && r_idx == '0 && r_mode == RK_HIT && r_item.operation == OP_LOOKUP
                    && r_valid[r_tgt]) begin
                    // first cycle: r_rd_* holds target entry
                    if (!(r_item.stamp_valid && r_rd_stamp == {r_item.stamp_size,
                          r_item.stamp_modified, r_item.stamp_created})) begin
                        n_mode = RK_DROP;
                        n_valid[r_tgt] = 1'b0;
                        n_live = r_live - CW'(1);
                        n_bytes = r_bytes - r_rd_cost;
                        n_ev = 10'd1;
                    end else begin
                        n_out.hit = 1'b1;
                        n_out.slot = 9'(r_tgt);
                        n_hits = r_hits + 32'd1;
                    end
                end
                if (r_idx != LAST) begin
                    n_idx = r_idx + AW'(1);
                end
                if (r_pv) begin
                    wr_addr = r_pidx;
                    if (pv_valid) begin
                        case (r_mode)
                            RK_DROP: begin
                                rk_we = r_rd_rank > r_rk;
                                rk_wdata = r_rd_rank - AW'(1);
                            end
                            RK_HIT: begin
                                rk_we = r_rd_rank < r_rk;
                                rk_wdata = r_rd_rank + AW'(1);
                                if (r_pidx == r_tgt) begin
                                    rk_we = 1'b1;
                                    rk_wdata = '0;
                                end
                            end
                            RK_ALL: begin
                                rk_we = 1'b1;
                                rk_wdata = r_rd_rank + AW'(1);
                            end
                            default: ;
                        endcase
                    end
                    if (r_pidx == LAST) begin
                        n_idx = '0;
                        if (r_mode == RK_ALL) begin
                            n_state = ST_STORE;
                        end else if (r_item.operation == OP_INSERT) begin
                            n_state = ST_EVCHK;
                        end else begin
                            n_state = ST_OUT;
                        end
                    end
                end else if (ENTRIES == 1) begin
                    n_state = ST_RANK;
                end
            end
            ST_EVCHK: begin
                n_idx = '0;
                if (r_live != '0 && over) begin
                    n_state = ST_EVSCAN;
                end else if (r_live >= CW'(ENTRIES)) begin
                    n_state = ST_OUT;
                end else begin
                    n_mode = RK_ALL;
                    n_state = ST_RANK;
                end
            end
            ST_EVSCAN: begin
                if (r_idx != LAST) begin
                    n_idx = r_idx + AW'(1);
                end
                if (r_pv) begin
                    if (pv_valid && CW'(r_rd_rank) == r_live - CW'(1)) begin
                        // least recent: drop it, no rank adjust needed (none higher)
                        n_valid[r_pidx] = 1'b0;
                        n_live = r_live - CW'(1);
                        n_bytes = r_bytes - r_rd_cost;
                        n_ev = r_ev + 10'd1;
                        n_state = ST_EVCHK;
                    end else if (r_pidx == LAST) begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_STORE: begin
                wr_en = 1'b1;
                rk_we = 1'b1;
                rk_wdata = '0;
                wr_addr = r_free;
                n_valid[r_free] = 1'b1;
                n_live = r_live + CW'(1);
                n_bytes = r_bytes + r_item.entry_bytes;
                n_out.stored = 1'b1;
                n_out.slot = 9'(r_free);
                n_state = ST_OUT;
            end
            ST_FLUSH: begin
                n_ev = 10'(r_live);
                n_valid = '0;
                n_live = '0;
                n_bytes = '0;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // wait here only while the previous word is still held
                if (!r_out_valid || !i_out_stall) begin
                    n_res = r_out;
                    n_res.evicted_count = r_ev;
                    n_res.entry_count = 10'(r_live);
                    n_res.bytes_used = r_bytes;
                    n_res.hit_total = r_hits;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        // lowest free slot tracked from valid bits before store
        if (r_state == ST_EVCHK) begin
            for (int k = ENTRIES - 1; k >= 0; k--) begin
                if (!r_valid[k]) begin
                    n_free = AW'(k);
                end
            end
        end
    end

    property p_stall_busy;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_in_stall;
    endproperty
    a_stall_busy: assert property (p_stall_busy) else $error("accepted while busy");

    property p_live_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CW'(ENTRIES);
    endproperty
    a_live_bound: assert property (p_live_bound) else $error("entry count overflow");

    property p_store_out;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STORE) |=> (r_state == ST_OUT);
    endproperty
    a_store_out: assert property (p_store_out) else $error("store not followed by result");

endmodule
